@@ sv/ldbw_pkg.sv @@
// Shared constants and types of the longest distinct-byte window block.
package ldbw_pkg;

   // Fixed field widths
   localparam int CHAR_WIDTH = 8;
   localparam int OUT_WIDTH  = 16;

   // Parameter defaults
   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int POS_WIDTH_DEF     = 16;

   // Largest table that keeps its valid bits in flip-flops
   localparam int VALID_FLOP_MAX = 256;

   // String tag width for tables above VALID_FLOP_MAX entries
   localparam int EPOCH_WIDTH = 8;

   // Table control from the pipeline
   typedef struct packed {
      logic rd_en;       // transaction accepted, look up its byte
      logic new_string;  // accepted byte begins a new string
      logic start_wait;  // a string start is offered on the input
      logic wr_en;       // window stage retires a byte
      logic wr_pending;  // window stage holds a byte not yet written
   } tbl_ctrl_type;

endpackage

@@ sv/longest_distinct_byte_window_core.sv @@
// Top level of the longest distinct-byte window block.
// Takes one byte per transaction and returns one result per byte: the longest
// run of distinct bytes in the current string and the length of the distinct
// window ending at that byte. A new byte is accepted every cycle while the
// result side keeps up; a result passes through the window stage and the
// output register before it is presented. The last-seen table is read at
// acceptance and written when the window stage retires the byte, with the
// write forwarded to a following read of the same byte value. With
// ALPHABET_SIZE up to 256 the table validity sits in flip-flops and a string
// start costs nothing. Above that, each entry carries a string tag; a clearing
// pass over all entries runs after reset and again before a string start once
// the tag has reached its last value, and no byte is taken during it.
// Once a string exceeds 2**POS_WIDTH - 1 bytes the overflow flag is raised and
// the position stays saturated until the next string start.
module longest_distinct_byte_window_core #(
   parameter int ALPHABET_SIZE = ldbw_pkg::ALPHABET_SIZE_DEF,
   parameter int POS_WIDTH     = ldbw_pkg::POS_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ldbw_pkg::CHAR_WIDTH-1:0] req_char_byte,
   input  logic                            req_string_start,
   input  logic                            req_string_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ldbw_pkg::OUT_WIDTH-1:0]  rsp_longest_so_far,
   output logic [ldbw_pkg::OUT_WIDTH-1:0]  rsp_window_length,
   output logic                            rsp_is_last,
   output logic                            rsp_overflow
);

   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam int CW    = ldbw_pkg::CHAR_WIDTH;
   localparam int OW    = ldbw_pkg::OUT_WIDTH;
   localparam logic [POS_WIDTH-1:0] MAXP = {POS_WIDTH{1'b1}};

   ldbw_pkg::tbl_ctrl_type tbl_ctrl;

   logic                 accept;
   logic                 out_free;
   logic                 s1_adv;
   logic                 tbl_ok;
   logic [SYM_W-1:0]     sym;
   logic [POS_WIDTH-1:0] rd_pos;
   logic                 rd_hit;

   // Position tracking at acceptance
   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic                 overflowed_ff, overflowed_in;
   logic [POS_WIDTH-1:0] pos_base;
   logic                 at_max;
   logic [POS_WIDTH-1:0] idx;

   // Window stage
   logic                 s1_valid_ff;
   logic [SYM_W-1:0]     s1_sym_ff;
   logic [POS_WIDTH-1:0] s1_idx_ff;
   logic                 s1_start_ff;
   logic                 s1_last_ff;
   logic                 s1_ovf_ff;
   logic [POS_WIDTH-1:0] ws_ff, ws_in;
   logic [POS_WIDTH-1:0] best_ff, best_in;
   logic [POS_WIDTH-1:0] ws_base, best_base, ws_a;
   logic [POS_WIDTH-1:0] wlen;
   logic [OW-1:0]        best_sat, wlen_sat;

   // Output register
   logic                 rsp_valid_ff;
   logic [OW-1:0]        rsp_longest_ff;
   logic [OW-1:0]        rsp_wlen_ff;
   logic                 rsp_last_ff;
   logic                 rsp_ovf_ff;

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = tbl_ok && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   // Reduce the byte to a table index
   generate
      if (ALPHABET_SIZE >= (1 << CW)) begin : g_sym_wide
         assign sym = SYM_W'(req_char_byte);
      end else if ((1 << SYM_W) == ALPHABET_SIZE) begin : g_sym_mask
         assign sym = req_char_byte[SYM_W-1:0];
      end else begin : g_sym_recip
         localparam int RECIP = (1 << (2 * CW)) / ALPHABET_SIZE;
         logic [3*CW:0]  prod;
         logic [CW-1:0]  q_est;
         logic [2*CW-1:0] qd;
         logic [CW:0]    rem0, rem1;

         // Estimate the quotient low by at most one, then correct once
         assign prod  = (3*CW+1)'(req_char_byte) * (3*CW+1)'(RECIP);
         assign q_est = prod[3*CW-1:2*CW];
         assign qd    = (2*CW)'(q_est) * (2*CW)'(ALPHABET_SIZE);
         assign rem0  = (CW+1)'(req_char_byte) - qd[CW:0];
         assign rem1  = (rem0 >= (CW+1)'(ALPHABET_SIZE)) ?
                        rem0 - (CW+1)'(ALPHABET_SIZE) : rem0;
         assign sym   = rem1[SYM_W-1:0];
      end
   endgenerate

   // Advance the position, saturating at the counter limit; the index stops one short of it
   always_comb begin
      pos_base      = req_string_start ? '0 : position_ff;
      overflowed_in = req_string_start ? 1'b0 : overflowed_ff;
      at_max        = (pos_base == MAXP);
      if (at_max) begin
         idx           = MAXP - POS_WIDTH'(1);
         position_in   = pos_base;
         overflowed_in = 1'b1;
      end else begin
         idx           = pos_base;
         position_in   = pos_base + POS_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         overflowed_ff <= 1'b0;
      end else if (accept) begin
         position_ff   <= position_in;
         overflowed_ff <= overflowed_in;
      end
   end

   // Load the window stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sym_ff   <= sym;
         s1_idx_ff   <= idx;
         s1_start_ff <= req_string_start;
         s1_last_ff  <= req_string_end;
         s1_ovf_ff   <= overflowed_in;
      end
   end

   // Last-seen table
   assign tbl_ctrl.rd_en      = accept;
   assign tbl_ctrl.new_string = req_string_start;
   assign tbl_ctrl.start_wait = req_valid && req_string_start;
   assign tbl_ctrl.wr_en      = s1_adv;
   assign tbl_ctrl.wr_pending = s1_valid_ff;

   ldbw_table #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .POS_WIDTH     (POS_WIDTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tbl_ctrl),
      .rd_addr   (sym),
      .wr_addr   (s1_sym_ff),
      .wr_pos    (s1_idx_ff + POS_WIDTH'(1)),
      .rd_pos    (rd_pos),
      .rd_hit    (rd_hit),
      .accept_ok (tbl_ok)
   );

   // Move the window start past a repeat and update the best length
   always_comb begin
      ws_base   = s1_start_ff ? '0 : ws_ff;
      best_base = s1_start_ff ? '0 : best_ff;
      ws_a      = (rd_hit && (rd_pos > ws_base)) ? rd_pos : ws_base;
      ws_in     = (ws_a > s1_idx_ff) ? s1_idx_ff : ws_a;
      wlen      = s1_idx_ff - ws_in + POS_WIDTH'(1);
      best_in   = (wlen > best_base) ? wlen : best_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= '0;
         best_ff <= '0;
      end else if (s1_adv) begin
         ws_ff   <= ws_in;
         best_ff <= best_in;
      end
   end

   // Fit lengths to the result width
   generate
      if (POS_WIDTH > OW) begin : g_sat
         assign best_sat = (|best_in[POS_WIDTH-1:OW]) ? {OW{1'b1}} : best_in[OW-1:0];
         assign wlen_sat = (|wlen[POS_WIDTH-1:OW]) ? {OW{1'b1}} : wlen[OW-1:0];
      end else begin : g_ext
         assign best_sat = OW'(best_in);
         assign wlen_sat = OW'(wlen);
      end
   endgenerate

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_longest_ff <= best_sat;
         rsp_wlen_ff    <= wlen_sat;
         rsp_last_ff    <= s1_last_ff;
         rsp_ovf_ff     <= s1_ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_longest_so_far = rsp_longest_ff;
   assign rsp_window_length  = rsp_wlen_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

@@ sv/ldbw_table.sv @@
// Last-seen position table with per-string validity and write forwarding.
module ldbw_table #(
   parameter int ALPHABET_SIZE = ldbw_pkg::ALPHABET_SIZE_DEF,
   parameter int POS_WIDTH     = ldbw_pkg::POS_WIDTH_DEF,
   localparam int SYM_W        = $clog2(ALPHABET_SIZE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ldbw_pkg::tbl_ctrl_type ctrl,
   input  logic [SYM_W-1:0]       rd_addr,
   input  logic [SYM_W-1:0]       wr_addr,
   input  logic [POS_WIDTH-1:0]   wr_pos,
   output logic [POS_WIDTH-1:0]   rd_pos,
   output logic                   rd_hit,
   output logic                   accept_ok
);

   logic                 fwd_in;
   logic                 fwd_ff;
   logic [POS_WIDTH-1:0] fwd_pos_ff;
   logic                 new_ff;

   // Catch a write to the entry being read at the same edge
   assign fwd_in = ctrl.wr_en && (wr_addr == rd_addr);

   // Hold forwarding data alongside the read
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         fwd_ff     <= fwd_in;
         fwd_pos_ff <= wr_pos;
         new_ff     <= ctrl.new_string;
      end
   end

   generate
      if (ALPHABET_SIZE <= ldbw_pkg::VALID_FLOP_MAX) begin : g_flop_valid
         logic [ALPHABET_SIZE-1:0] valid_ff;
         logic [ALPHABET_SIZE-1:0] valid_in;
         logic [POS_WIDTH-1:0]     mem [ALPHABET_SIZE];
         logic [POS_WIDTH-1:0]     q_ff;
         logic                     vhit_ff;

         // Clear all valid bits at a string start, else mark the retired entry
         always_comb begin
            valid_in = valid_ff;
            priority if (ctrl.rd_en && ctrl.new_string) begin
               valid_in = '0;
            end else if (ctrl.wr_en) begin
               valid_in[wr_addr] = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff <= '0;
            end else begin
               valid_ff <= valid_in;
            end
         end

         // Position memory
         always_ff @(posedge clock) begin
            if (ctrl.wr_en) begin
               mem[wr_addr] <= wr_pos;
            end
            if (ctrl.rd_en) begin
               q_ff    <= mem[rd_addr];
               vhit_ff <= valid_ff[rd_addr];
            end
         end

         assign rd_pos    = fwd_ff ? fwd_pos_ff : q_ff;
         assign rd_hit    = !new_ff && (fwd_ff || vhit_ff);
         assign accept_ok = 1'b1;
      end else begin : g_epoch_valid
         localparam int EW = ldbw_pkg::EPOCH_WIDTH;

         logic [EW+POS_WIDTH-1:0] mem [ALPHABET_SIZE];
         logic [EW+POS_WIDTH-1:0] q_ff;
         logic [EW-1:0]           epoch_ff;
         logic                    sweep_ff;
         logic [SYM_W-1:0]        cnt_ff;
         logic                    wait_wrap;
         logic                    sweep_go;
         logic                    we;
         logic [SYM_W-1:0]        wa;
         logic [EW+POS_WIDTH-1:0] wd;

         // A start on the last tag waits for a clearing pass
         assign wait_wrap = ctrl.start_wait && (epoch_ff == {EW{1'b1}});
         assign sweep_go  = !sweep_ff && wait_wrap && !ctrl.wr_pending;

         // Sweep the table after reset and before the tag wraps
         always_ff @(posedge clock) begin
            if (reset) begin
               sweep_ff <= 1'b1;
               cnt_ff   <= '0;
               epoch_ff <= '0;
            end else begin
               priority if (sweep_ff) begin
                  cnt_ff <= cnt_ff + SYM_W'(1);
                  if (cnt_ff == SYM_W'(ALPHABET_SIZE - 1)) begin
                     sweep_ff <= 1'b0;
                     epoch_ff <= EW'(1);
                  end
               end else if (sweep_go) begin
                  sweep_ff <= 1'b1;
                  cnt_ff   <= '0;
               end else if (ctrl.rd_en && ctrl.new_string) begin
                  epoch_ff <= epoch_ff + EW'(1);
               end
            end
         end

         assign we = sweep_ff || ctrl.wr_en;
         assign wa = sweep_ff ? cnt_ff : wr_addr;
         assign wd = sweep_ff ? '0 : {epoch_ff, wr_pos};

         // Tagged position memory
         always_ff @(posedge clock) begin
            if (we) begin
               mem[wa] <= wd;
            end
            if (ctrl.rd_en) begin
               q_ff <= mem[rd_addr];
            end
         end

         assign rd_pos    = fwd_ff ? fwd_pos_ff : q_ff[POS_WIDTH-1:0];
         assign rd_hit    = !new_ff &&
                            (fwd_ff || (q_ff[EW+POS_WIDTH-1:POS_WIDTH] == epoch_ff));
         assign accept_ok = !sweep_ff && !wait_wrap;
      end
   endgenerate

endmodule
